/* rtl/core/lph_pkg.sv */
// shared constants, types and helpers of the linear probe hash table
`default_nettype none
package lph_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int KEY_W      = 31;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 3;

    // remainder unit: key padded to an even width, two bits retired per cycle
    localparam int MOD_IN_W   = KEY_W + (KEY_W % 2);
    localparam int MOD_STEPS  = MOD_IN_W / 2;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    // configuration register indexes
    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_FILL_LIMIT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MOD,
        FSM_PROBE,
        FSM_REPLY
    } fsm_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
        logic [CFG_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } mod_rsp_t;

    typedef struct packed {
        logic                  wr_key;
        logic                  wr_val;
        logic [IDX_W-1:0]      addr;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
    } store_wr_t;

    typedef struct packed {
        logic             occupied;
        logic [KEY_W-1:0] key;
    } store_rd_t;

    // size in use: zero acts as one, anything above the capacity as the capacity
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] ts);
        logic [CFG_W-1:0] res;
        begin
            res = ts;
            if (ts == '0) begin
                res = CFG_W'(1);
            end else if (int'(ts) > CAPACITY) begin
                res = CFG_W'(CAPACITY);
            end
            return res;
        end
    endfunction

    // one restoring remainder step; r stays below d
    function automatic logic [CFG_W-1:0] rem_step(input logic [CFG_W-1:0] r,
                                                  input logic b,
                                                  input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] t;
        begin
            t = {r[CFG_W-2:0], b};
            if (t >= d) begin
                t = t - d;
            end
            return t;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/lph_mod_unit.sv */
// iterative key modulo table size, two quotient bits per cycle
`default_nettype none
module lph_mod_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lph_pkg::mod_req_t req,
    output lph_pkg::mod_rsp_t      rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [lph_pkg::MOD_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [lph_pkg::MOD_IN_W-1:0]      sh_reg, sh_next;
    logic [lph_pkg::CFG_W-1:0]         rem_reg, rem_next;
    logic [lph_pkg::CFG_W-1:0]         div_reg, div_next;
    logic [lph_pkg::CFG_W-1:0]         rem_mid;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        rem_mid   = lph_pkg::rem_step(rem_reg, sh_reg[lph_pkg::MOD_IN_W-1], div_reg);
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = lph_pkg::MOD_IN_W'(req.key);
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = lph_pkg::rem_step(rem_mid, sh_reg[lph_pkg::MOD_IN_W-2], div_reg);
            sh_next  = {sh_reg[lph_pkg::MOD_IN_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lph_pkg::MOD_CNT_W'(lph_pkg::MOD_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

/* rtl/core/lph_store.sv */
// slot keys, values and occupied marks
`default_nettype none
module lph_store (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lph_pkg::store_wr_t          wr,
    input  wire logic [lph_pkg::IDX_W-1:0]   rd_addr,
    output lph_pkg::store_rd_t               rd
);

    logic [lph_pkg::KEY_W-1:0]      keys_reg [lph_pkg::CAPACITY];
    logic [lph_pkg::VALUE_BITS-1:0] values_reg [lph_pkg::CAPACITY];
    logic [lph_pkg::CAPACITY-1:0]   occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (wr.wr_key) begin
            occ_reg[wr.addr] <= 1'b1;
        end
        if (wr.wr_key) begin
            keys_reg[wr.addr] <= wr.key;
        end
        if (wr.wr_val) begin
            values_reg[wr.addr] <= wr.value;
        end
    end

    assign rd.occupied = occ_reg[rd_addr];
    assign rd.key      = keys_reg[rd_addr];

endmodule
`default_nettype wire

/* rtl/core/lph_ctrl.sv */
// sequencer: fill check, hash, probe walk and result register
`default_nettype none
module lph_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_mode,
    input  wire logic [lph_pkg::KEY_W-1:0]        s_key,
    input  wire logic [lph_pkg::VALUE_BITS-1:0]   s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [lph_pkg::STATUS_W-1:0]          m_status,
    output logic [lph_pkg::SLOT_W-1:0]            m_slot,
    input  wire logic [lph_pkg::CFG_W-1:0]        eff_size,
    input  wire logic [lph_pkg::CFG_W-1:0]        fill_limit,
    output lph_pkg::mod_req_t                     mod_req,
    input  wire lph_pkg::mod_rsp_t                mod_rsp,
    output lph_pkg::store_wr_t                    store_wr,
    output logic [lph_pkg::IDX_W-1:0]             rd_addr,
    input  wire lph_pkg::store_rd_t               store_rd
);

    lph_pkg::fsm_t                    state_reg, state_next;
    logic                             mode_reg, mode_next;
    logic [lph_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [lph_pkg::VALUE_BITS-1:0]   val_reg, val_next;
    logic [lph_pkg::CFG_W-1:0]        pos_reg, pos_next;
    logic [lph_pkg::CFG_W-1:0]        step_reg, step_next;
    logic [lph_pkg::CFG_W-1:0]        count_reg, count_next;
    lph_pkg::status_t                 status_reg, status_next;
    logic [lph_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic                             out_valid_reg, out_valid_next;
    logic [lph_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [lph_pkg::SLOT_W-1:0]       out_slot_reg, out_slot_next;
    logic                             out_free;
    logic [lph_pkg::CFG_W-1:0]        pos_inc;

    assign out_free = !out_valid_reg || m_ready;
    assign pos_inc  = pos_reg + 1'b1;
    assign rd_addr  = lph_pkg::IDX_W'(pos_reg);

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        s_ready         = 1'b0;
        mod_req.start   = 1'b0;
        mod_req.key     = s_key;
        mod_req.divisor = eff_size;
        store_wr.wr_key = 1'b0;
        store_wr.wr_val = 1'b0;
        store_wr.addr   = lph_pkg::IDX_W'(pos_reg);
        store_wr.key    = key_reg;
        store_wr.value  = val_reg;

        case (state_reg)
            lph_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mode_next = s_mode;
                    key_next  = s_key;
                    val_next  = s_value;
                    if (!s_mode && (count_reg >= fill_limit)) begin
                        status_next = lph_pkg::STAT_FULL;
                        slot_next   = '0;
                        state_next  = lph_pkg::FSM_REPLY;
                    end else begin
                        mod_req.start = 1'b1;
                        state_next    = lph_pkg::FSM_MOD;
                    end
                end
            end
            lph_pkg::FSM_MOD: begin
                if (mod_rsp.done) begin
                    pos_next   = mod_rsp.rem;
                    step_next  = '0;
                    state_next = lph_pkg::FSM_PROBE;
                end
            end
            lph_pkg::FSM_PROBE: begin
                if (!store_rd.occupied) begin
                    state_next = lph_pkg::FSM_REPLY;
                    if (mode_reg) begin
                        status_next = lph_pkg::STAT_NOT_FOUND;
                        slot_next   = '0;
                    end else begin
                        store_wr.wr_key = 1'b1;
                        store_wr.wr_val = 1'b1;
                        count_next      = count_reg + 1'b1;
                        status_next     = lph_pkg::STAT_INSERTED;
                        slot_next       = lph_pkg::SLOT_W'(pos_reg);
                    end
                end else if (store_rd.key == key_reg) begin
                    state_next = lph_pkg::FSM_REPLY;
                    slot_next  = lph_pkg::SLOT_W'(pos_reg);
                    if (mode_reg) begin
                        status_next = lph_pkg::STAT_FOUND;
                    end else begin
                        store_wr.wr_val = 1'b1;
                        status_next     = lph_pkg::STAT_UPDATED;
                    end
                end else if (step_reg + 1'b1 == eff_size) begin
                    // walked every slot in use without a match or a hole
                    state_next  = lph_pkg::FSM_REPLY;
                    slot_next   = '0;
                    status_next = mode_reg ? lph_pkg::STAT_NOT_FOUND : lph_pkg::STAT_FULL;
                end else begin
                    pos_next  = (pos_inc == eff_size) ? '0 : pos_inc;
                    step_next = step_reg + 1'b1;
                end
            end
            lph_pkg::FSM_REPLY: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_slot_next   = slot_reg;
                    state_next      = lph_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = lph_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lph_pkg::FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_slot   = out_slot_reg;

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lph_pkg::FSM_PROBE |-> pos_reg < eff_size)
        else $error("probe position outside table size");

    a_count_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> count_reg == lph_pkg::CFG_W'($past(count_reg) + 1'b1))
        else $error("entry count moved by more than one");

    a_insert_under_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        store_wr.wr_key |-> count_reg < fill_limit)
        else $error("new key stored at or above fill limit");

    a_mod_done_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_rsp.done |-> state_reg == lph_pkg::FSM_MOD)
        else $error("remainder finished outside hash state");

    a_reply_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lph_pkg::FSM_REPLY && out_free |=> out_valid_reg)
        else $error("reply not moved to output register");

endmodule
`default_nettype wire

/* rtl/core/linear_probe_hash_table_top.sv */
// top level of the linear probe hash table: config registers and block wiring
`default_nettype none
// Open-addressing hash table with linear probing over up to 16 slots. Each input word
// is an insert/update (mode 0) or a search (mode 1) and gives one result word. The
// home slot is key mod the table size in use, computed by a restoring remainder unit
// that retires two key bits per cycle, then one slot is probed per cycle for up to
// the table size in use; an insert refused at the fill limit skips both steps.
// The input is not ready while an item is at work; a finished result sits in an output
// register, so the next word is taken while it waits. Config writes (cfg_addr 0
// table_size, 1 fill_limit) are meant for idle periods only.
module linear_probe_hash_table_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_mode,
    input  wire logic [lph_pkg::KEY_W-1:0]        s_key,
    input  wire logic [lph_pkg::VALUE_BITS-1:0]   s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [lph_pkg::STATUS_W-1:0]          m_status,
    output logic [lph_pkg::SLOT_W-1:0]            m_slot,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_addr,
    input  wire logic [lph_pkg::CFG_W-1:0]        cfg_wdata
);

    logic [lph_pkg::CFG_W-1:0] table_size_reg;
    logic [lph_pkg::CFG_W-1:0] fill_limit_reg;
    logic [lph_pkg::CFG_W-1:0] eff_size;
    logic [lph_pkg::IDX_W-1:0] rd_addr;
    lph_pkg::mod_req_t         mod_req;
    lph_pkg::mod_rsp_t         mod_rsp;
    lph_pkg::store_wr_t        store_wr;
    lph_pkg::store_rd_t        store_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= lph_pkg::CFG_W'(10);
            fill_limit_reg <= lph_pkg::CFG_W'(6);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lph_pkg::CFG_TABLE_SIZE: table_size_reg <= cfg_wdata;
                lph_pkg::CFG_FILL_LIMIT: fill_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign eff_size = lph_pkg::eff_size(table_size_reg);

    lph_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    lph_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (store_wr),
        .rd_addr (rd_addr),
        .rd      (store_rd)
    );

    lph_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_key      (s_key),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_slot     (m_slot),
        .eff_size   (eff_size),
        .fill_limit (fill_limit_reg),
        .mod_req    (mod_req),
        .mod_rsp    (mod_rsp),
        .store_wr   (store_wr),
        .rd_addr    (rd_addr),
        .store_rd   (store_rd)
    );

endmodule
`default_nettype wire
